// ----- sv/afc_pkg.sv -----
// shared types and constants of the box frustum culling pipeline
package afc_pkg;

  // default geometry of the box coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // matrix entries and plane coefficients
  localparam int ENTRY_W   = 32;
  localparam int PL_W      = ENTRY_W + 1;
  localparam int NUM_PLANE = 6;
  localparam int NUM_AXIS  = 3;

  // configuration port: eight 64-bit matrix registers
  localparam int CFG_DATA_W = 2 * ENTRY_W;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = REG_IDX_W + 1;

  // one frustum plane: normal and offset
  typedef struct packed {
    logic signed [PL_W-1:0] nx;
    logic signed [PL_W-1:0] ny;
    logic signed [PL_W-1:0] nz;
    logic signed [PL_W-1:0] w;
  } plane_t;

  // stage load enables, one per register stage after the input stage
  typedef struct packed {
    logic pp;
    logic prod;
    logic pair;
    logic out;
  } stage_en_t;

endpackage

// ----- sv/aabb_frustum_cull_top.sv -----
// top level of the box against six plane frustum culling pipeline
//
// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
// box in  | in_valid, in_ready, box_min_*, box_max_*       | in
// result  | out_valid, out_ready, visible                  | out
//
// one box per cycle while out_ready is held high; an accepted box passes the
// input register, partial products, product recombine, pair sums, sign and
// output register. each stage holds its own valid bit and loads when empty or
// when the stage after it moves, so bubbles close up under a stall and no word
// is lost or repeated. synchronous reset clears the matrix and the valid bits.
// a write reaches the planes through their register; cfg_ready is always high.
module aabb_frustum_cull_top #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = afc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [afc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      box_min_x,
  input  logic signed [COORD_WIDTH-1:0]      box_min_y,
  input  logic signed [COORD_WIDTH-1:0]      box_min_z,
  input  logic signed [COORD_WIDTH-1:0]      box_max_x,
  input  logic signed [COORD_WIDTH-1:0]      box_max_y,
  input  logic signed [COORD_WIDTH-1:0]      box_max_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               visible
);

  localparam int NUM_STG = 5;
  localparam int PROD_W  = afc_pkg::PL_W + COORD_WIDTH;

  logic [NUM_STG-1:0] vld;
  logic [NUM_STG-1:0] ld;
  afc_pkg::stage_en_t en;

  afc_pkg::plane_t             plane [afc_pkg::NUM_PLANE];
  logic signed [COORD_WIDTH-1:0] bmin  [afc_pkg::NUM_AXIS];
  logic signed [COORD_WIDTH-1:0] bmax  [afc_pkg::NUM_AXIS];
  logic signed [PROD_W-1:0]    prod  [afc_pkg::NUM_PLANE][afc_pkg::NUM_AXIS];

  assign cfg_ready = 1'b1;

  // stage load enables, from the output back to the input
  always_comb begin
    ld[NUM_STG-1] = !vld[NUM_STG-1] || out_ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
    en.pp   = ld[1];
    en.prod = ld[2];
    en.pair = ld[3];
    en.out  = ld[4];
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NUM_STG-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      bmin[0] <= box_min_x;
      bmin[1] <= box_min_y;
      bmin[2] <= box_min_z;
      bmax[0] <= box_max_x;
      bmax[1] <= box_max_y;
      bmax[2] <= box_max_z;
    end
  end

  afc_planes u_planes (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plane     (plane)
  );

  afc_mul #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .clk   (clk),
    .en    (en),
    .plane (plane),
    .bmin  (bmin),
    .bmax  (bmax),
    .prod  (prod)
  );

  afc_sum #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_sum (
    .clk     (clk),
    .en      (en),
    .plane   (plane),
    .prod    (prod),
    .visible (visible)
  );

endmodule

// ----- sv/afc_planes.sv -----
// matrix registers and derivation of the six frustum planes
module afc_planes (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [afc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output afc_pkg::plane_t                      plane [afc_pkg::NUM_PLANE]
);

  logic [afc_pkg::CFG_DATA_W-1:0] mat [afc_pkg::NUM_REGS];

  // matrix register writes, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < afc_pkg::NUM_REGS; i++) begin
        mat[i] <= '0;
      end
    end else if (cfg_valid &&
                 (cfg_index < afc_pkg::CFG_IDX_W'(afc_pkg::NUM_REGS))) begin
      mat[cfg_index[afc_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // planes: row 3 plus or minus rows 0, 1, 2, registered
  for (genvar k = 0; k < afc_pkg::NUM_PLANE; k++) begin : g_plane
    localparam int ROW   = k / 2;
    localparam bit MINUS = (k % 2) == 1;

    logic signed [afc_pkg::PL_W-1:0] coef [4];

    always_comb begin
      logic signed [afc_pkg::ENTRY_W-1:0] a;
      logic signed [afc_pkg::ENTRY_W-1:0] b;
      for (int c = 0; c < 4; c++) begin
        a = mat[6 + c / 2][(c % 2) * afc_pkg::ENTRY_W +: afc_pkg::ENTRY_W];
        b = mat[ROW * 2 + c / 2][(c % 2) * afc_pkg::ENTRY_W +: afc_pkg::ENTRY_W];
        if (MINUS) begin
          coef[c] = afc_pkg::PL_W'(a) - afc_pkg::PL_W'(b);
        end else begin
          coef[c] = afc_pkg::PL_W'(a) + afc_pkg::PL_W'(b);
        end
      end
    end

    always_ff @(posedge clk) begin
      plane[k].nx <= coef[0];
      plane[k].ny <= coef[1];
      plane[k].nz <= coef[2];
      plane[k].w  <= coef[3];
    end
  end

endmodule

// ----- sv/afc_mul.sv -----
// positive vertex choice and plane normal times vertex products, two stages
module afc_mul #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  afc_pkg::stage_en_t                     en,
  input  afc_pkg::plane_t                        plane [afc_pkg::NUM_PLANE],
  input  logic signed [COORD_WIDTH-1:0]          bmin  [afc_pkg::NUM_AXIS],
  input  logic signed [COORD_WIDTH-1:0]          bmax  [afc_pkg::NUM_AXIS],
  output logic signed [afc_pkg::PL_W+COORD_WIDTH-1:0]
                                                 prod  [afc_pkg::NUM_PLANE][afc_pkg::NUM_AXIS]
);

  localparam int LO_W   = COORD_WIDTH / 2;
  localparam int HI_W   = COORD_WIDTH - LO_W;
  localparam int PPL_W  = afc_pkg::PL_W + LO_W + 1;
  localparam int PPH_W  = afc_pkg::PL_W + HI_W;
  localparam int PROD_W = afc_pkg::PL_W + COORD_WIDTH;

  logic signed [PPL_W-1:0] pp_lo [afc_pkg::NUM_PLANE][afc_pkg::NUM_AXIS];
  logic signed [PPH_W-1:0] pp_hi [afc_pkg::NUM_PLANE][afc_pkg::NUM_AXIS];

  for (genvar k = 0; k < afc_pkg::NUM_PLANE; k++) begin : g_plane
    for (genvar a = 0; a < afc_pkg::NUM_AXIS; a++) begin : g_axis
      logic signed [afc_pkg::PL_W-1:0] n;
      logic signed [COORD_WIDTH-1:0]   p;
      logic signed [LO_W:0]            p_lo;
      logic signed [HI_W-1:0]          p_hi;

      // normal component and positive vertex for this axis
      always_comb begin
        unique case (a)
          0:       n = plane[k].nx;
          1:       n = plane[k].ny;
          default: n = plane[k].nz;
        endcase
        p    = n[afc_pkg::PL_W-1] ? bmin[a] : bmax[a];
        p_lo = $signed({1'b0, p[LO_W-1:0]});
        p_hi = $signed(p[COORD_WIDTH-1:LO_W]);
      end

      // half-width partial products
      always_ff @(posedge clk) begin
        if (en.pp) begin
          pp_lo[k][a] <= PPL_W'(n * p_lo);
          pp_hi[k][a] <= PPH_W'(n * p_hi);
        end
      end

      // recombine the halves into the exact product
      always_ff @(posedge clk) begin
        if (en.prod) begin
          prod[k][a] <= (PROD_W'(pp_hi[k][a]) <<< LO_W) + PROD_W'(pp_lo[k][a]);
        end
      end
    end
  end

endmodule

// ----- sv/afc_sum.sv -----
// per plane sums, sign test and the visibility register
module afc_sum #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = afc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  afc_pkg::stage_en_t                     en,
  input  afc_pkg::plane_t                        plane [afc_pkg::NUM_PLANE],
  input  logic signed [afc_pkg::PL_W+COORD_WIDTH-1:0]
                                                 prod  [afc_pkg::NUM_PLANE][afc_pkg::NUM_AXIS],
  output logic                                   visible
);

  localparam int PROD_W = afc_pkg::PL_W + COORD_WIDTH;
  localparam int W_W    = afc_pkg::PL_W + FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > W_W) ? PROD_W : W_W) + 2;

  logic signed [ACC_W-1:0] sum_xy [afc_pkg::NUM_PLANE];
  logic signed [ACC_W-1:0] sum_zw [afc_pkg::NUM_PLANE];
  logic [afc_pkg::NUM_PLANE-1:0] reject;

  // pairwise sums: x plus y, z plus offset scaled to the product format
  always_ff @(posedge clk) begin
    if (en.pair) begin
      for (int k = 0; k < afc_pkg::NUM_PLANE; k++) begin
        sum_xy[k] <= ACC_W'(prod[k][0]) + ACC_W'(prod[k][1]);
        sum_zw[k] <= ACC_W'(prod[k][2]) + (ACC_W'(plane[k].w) <<< FRAC_BITS);
      end
    end
  end

  // a negative total puts the box outside that plane
  always_comb begin
    logic signed [ACC_W-1:0] tot;
    for (int k = 0; k < afc_pkg::NUM_PLANE; k++) begin
      tot       = sum_xy[k] + sum_zw[k];
      reject[k] = tot[ACC_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en.out) begin
      visible <= ~|reject;
    end
  end

endmodule

// ----- sv/afc_checker.sv -----
// port level checks of the culling pipeline and their binding to the top level
module afc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words inside the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible))
    else $error("result changed under stall");

  // no result without an accepted box, never more than five in flight
  a_count: assert property (@(posedge clk) disable iff (rst)
    (!out_acc || cnt != 3'd0) && cnt <= 3'd5)
    else $error("result count out of step with accepted boxes");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // with the consumer held ready, an accepted box always yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result late");

endmodule

bind aabb_frustum_cull_top afc_checker u_afc_checker (.*);
